/* hw/rtl/cdtd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the CFF DICT token decoder.
// No dependencies; imported by every module of the block.
package cdtd_pkg;

	// mantissa holds up to 18 decimal digits, which fit in 60 bits
	localparam int MANT_DIGITS = 18;
	localparam int MANT_W      = 60;
	localparam int DIG_W       = 5;
	localparam int EXP_W       = 11;
	localparam int INT_W       = 32;
	localparam int OP_W        = 5;
	localparam int TDATA_W     = 112;

	// scale and exponent limits
	localparam logic signed [EXP_W-1:0] SCALE_MAX   = EXP_W'(2**(EXP_W-1) - 1);
	localparam logic signed [EXP_W-1:0] SCALE_MIN   = EXP_W'(-(2**(EXP_W-1)));
	localparam logic [EXP_W-1:0]        EXP_ACC_MAX = EXP_W'(2**EXP_W - 1);

	// token kinds
	localparam logic [1:0] KIND_OP   = 2'd0;
	localparam logic [1:0] KIND_INT  = 2'd1;
	localparam logic [1:0] KIND_REAL = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_END       = 2'd1;
	localparam logic [1:0] ERR_RSVD      = 2'd2;
	localparam logic [1:0] ERR_MALFORMED = 2'd3;

	// lead byte codes
	localparam logic [7:0] OP_LAST        = 8'd21;
	localparam logic [7:0] RSVD_LAST      = 8'd27;
	localparam logic [7:0] LEAD_INT16     = 8'd28;
	localparam logic [7:0] LEAD_INT32     = 8'd29;
	localparam logic [7:0] LEAD_REAL      = 8'd30;
	localparam logic [7:0] RSVD_31        = 8'd31;
	localparam logic [7:0] SHORT_FIRST    = 8'd32;
	localparam logic [7:0] SHORT_LAST     = 8'd246;
	localparam logic [7:0] LEAD_POS_FIRST = 8'd247;
	localparam logic [7:0] LEAD_POS_LAST  = 8'd250;
	localparam logic [7:0] LEAD_NEG_FIRST = 8'd251;
	localparam logic [7:0] LEAD_NEG_LAST  = 8'd254;
	localparam logic [7:0] RSVD_255       = 8'd255;

	// integer biases
	localparam logic [INT_W-1:0] SHORT_BIAS = INT_W'(139);
	localparam logic [INT_W-1:0] INT2_BIAS  = INT_W'(108);

	// class of a byte seen at token start
	typedef enum logic [2:0] {
		CLS_OP,
		CLS_REAL,
		CLS_RSVD,
		CLS_SHORT,
		CLS_LEAD
	} cls_t;

	// queue entry between front and back
	typedef struct packed {
		logic [7:0] byte_value;
		logic       stream_end;
		cls_t       cls;
	} q_item_t;

	// token as the back part leaves it, before sign and exponent fix-up
	typedef struct packed {
		logic [1:0]              kind;
		logic [OP_W-1:0]         op_code;
		logic [INT_W-1:0]        int_val;
		logic [MANT_W-1:0]       mant;
		logic                    neg;
		logic                    exp_neg;
		logic [EXP_W-1:0]        exp_acc;
		logic signed [EXP_W-1:0] scale;
		logic                    lost;
		logic [1:0]              err;
	} raw_tok_t;

endpackage

/* hw/rtl/cdtd_front.sv */
`timescale 1ns / 1ps
// Front part: classifies incoming bytes and holds them in a two-entry queue.
// Depends on cdtd_pkg.
module cdtd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] byte_value
	input  logic              s_tuser,   // [0] stream_end
	output logic              q_valid,
	input  logic              q_pop,
	output cdtd_pkg::q_item_t q_item
);
	import cdtd_pkg::*;

	localparam logic [1:0] Q_FULL = 2'd2;

	q_item_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cls_t       cls;
	q_item_t    item_in;
	logic       push;

	// class of the byte if it starts a token
	always_comb begin
		priority if (s_tdata <= OP_LAST) begin
			cls = CLS_OP;
		end else if (s_tdata == LEAD_REAL) begin
			cls = CLS_REAL;
		end else if (s_tdata <= RSVD_LAST || s_tdata == RSVD_31 || s_tdata == RSVD_255) begin
			cls = CLS_RSVD;
		end else if (s_tdata >= SHORT_FIRST && s_tdata <= SHORT_LAST) begin
			cls = CLS_SHORT;
		end else begin
			cls = CLS_LEAD;
		end
	end

	assign item_in  = '{byte_value: s_tdata, stream_end: s_tuser, cls: cls};
	assign s_tready = (count_q != Q_FULL);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop)
				count_q <= count_q + 2'd1;
			else if (!push && q_pop)
				count_q <= count_q - 2'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= item_in;
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back part popped an empty queue");
`endif

endmodule

/* hw/rtl/cdtd_back.sv */
`timescale 1ns / 1ps
// Back part: token state machine, integer assembly and real nibble decoding.
// Depends on cdtd_pkg; feeds cdtd_emit through a one-entry stage register.
module cdtd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  cdtd_pkg::q_item_t  q_item,
	output logic               tok_valid_s1,
	output cdtd_pkg::raw_tok_t tok_s1,
	input  logic               tok_take
);
	import cdtd_pkg::*;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_INT   = 2'd1;
	localparam logic [1:0] PH_REAL  = 2'd2;

	localparam logic [1:0] NIB_MORE      = 2'd0;
	localparam logic [1:0] NIB_DONE      = 2'd1;
	localparam logic [1:0] NIB_RESERVED  = 2'd2;
	localparam logic [1:0] NIB_MALFORMED = 2'd3;

	localparam logic [3:0] NC_DIGIT_MAX = 4'h9;
	localparam logic [3:0] NC_POINT     = 4'ha;
	localparam logic [3:0] NC_EXP_POS   = 4'hb;
	localparam logic [3:0] NC_EXP_NEG   = 4'hc;
	localparam logic [3:0] NC_MINUS     = 4'he;
	localparam logic [3:0] NC_END       = 4'hf;

	localparam int PROD_W = MANT_W + 7;
	localparam int EACC_W = EXP_W + 4;

	typedef struct packed {
		logic [MANT_W-1:0]       mant;
		logic [DIG_W-1:0]        digits;
		logic [EXP_W-1:0]        exp_acc;
		logic signed [EXP_W-1:0] scale;
		logic                    past_int;
		logic                    in_exp;
		logic                    exp_neg;
		logic                    neg;
		logic                    started;
		logic                    lost;
	} real_st_t;

	typedef struct packed {
		real_st_t   st;
		logic [1:0] res;
		logic       entered;
	} nib_out_t;

	// one nibble of a real; mant_next is the mantissa if this digit enters it
	function automatic nib_out_t nib_step(input real_st_t st, input logic [3:0] n,
			input logic [MANT_W-1:0] mant_next);
		nib_out_t          o;
		logic [EACC_W-1:0] e;
		logic              frac;
		o         = '0;
		o.st      = st;
		o.res     = NIB_MORE;
		o.entered = 1'b0;
		frac      = st.past_int;
		e         = EACC_W'(st.exp_acc) * EACC_W'(10) + EACC_W'(n);
		priority if (n <= NC_DIGIT_MAX) begin
			if (!(st.past_int && st.in_exp)) begin
				if (st.digits < DIG_W'(MANT_DIGITS)) begin
					o.entered = 1'b1;
					o.st.mant = mant_next;
					if (mant_next != '0)
						o.st.digits = st.digits + DIG_W'(1);
					if (frac) begin
						if (st.scale == SCALE_MIN)
							o.st.lost = 1'b1;
						else
							o.st.scale = st.scale - EXP_W'(1);
					end
				end else begin
					if (!frac) begin
						if (st.scale == SCALE_MAX)
							o.st.lost = 1'b1;
						else
							o.st.scale = st.scale + EXP_W'(1);
					end
					if (n != 4'h0)
						o.st.lost = 1'b1;
				end
			end else begin
				if (e > EACC_W'(EXP_ACC_MAX)) begin
					o.st.exp_acc = EXP_ACC_MAX;
					o.st.lost    = 1'b1;
				end else begin
					o.st.exp_acc = e[EXP_W-1:0];
				end
			end
		end else if (n == NC_POINT) begin
			if (st.past_int)
				o.res = NIB_MALFORMED;
			o.st.past_int = 1'b1;
		end else if (n == NC_EXP_POS || n == NC_EXP_NEG) begin
			if (st.in_exp)
				o.res = NIB_MALFORMED;
			o.st.past_int = 1'b1;
			o.st.in_exp   = 1'b1;
			if (n == NC_EXP_NEG)
				o.st.exp_neg = 1'b1;
		end else if (n == NC_MINUS) begin
			if (st.started)
				o.res = NIB_MALFORMED;
			o.st.neg = 1'b1;
		end else if (n == NC_END) begin
			o.res = NIB_DONE;
		end else begin
			o.res = NIB_RESERVED;
		end
		o.st.started = 1'b1;
		return o;
	endfunction

	logic [1:0]       phase_q, phase_d;
	logic [2:0]       left_q, left_d;
	logic [7:0]       lead_q, lead_d;
	logic [INT_W-1:0] acc_q, acc_d;
	real_st_t         rs_q, rs_d;

	logic              process;
	logic              emit;
	raw_tok_t          tok;
	logic [7:0]        b;
	logic [3:0]        hi, lo;
	logic [PROD_W-1:0] m_wide, m10, m100;
	logic [7:0]        hi10;
	logic [MANT_W-1:0] mant1, mant2;
	nib_out_t          n1, n2;
	real_st_t          rs_fin;
	logic [1:0]        r_fin;
	logic [INT_W-1:0]  acc_next;
	logic [7:0]        pos_off, neg_off;
	logic [INT_W-1:0]  pos_val, neg_mag, neg_val, int16_val, short_val;

	assign b       = q_item.byte_value;
	assign hi      = b[7:4];
	assign lo      = b[3:0];
	assign process = q_valid && (!tok_valid_s1 || tok_take);
	assign q_pop   = process;

	// mantissa times 10 and times 100, as shift-add terms
	assign m_wide = PROD_W'(rs_q.mant);
	assign m10    = (m_wide << 3) + (m_wide << 1);
	assign m100   = (m_wide << 6) + (m_wide << 5) + (m_wide << 2);
	assign hi10   = {4'h0, hi} * 8'd10;
	assign mant1  = m10[MANT_W-1:0] + MANT_W'(hi);
	assign mant2  = n1.entered ? MANT_W'(m100 + PROD_W'(hi10) + PROD_W'(lo))
		: MANT_W'(m10 + PROD_W'(lo));

	// both nibbles of a real byte; the low one only if the high one goes on
	assign n1     = nib_step(rs_q, hi, mant1);
	assign n2     = nib_step(n1.st, lo, mant2);
	assign rs_fin = (n1.res == NIB_MORE) ? n2.st : n1.st;
	assign r_fin  = (n1.res == NIB_MORE) ? n2.res : n1.res;

	// integer operand values
	assign acc_next  = {acc_q[INT_W-9:0], b};
	assign pos_off   = lead_q - LEAD_POS_FIRST;
	assign neg_off   = lead_q - LEAD_NEG_FIRST;
	assign pos_val   = INT_W'({pos_off[1:0], b}) + INT2_BIAS;
	assign neg_mag   = INT_W'({neg_off[1:0], b}) + INT2_BIAS;
	assign neg_val   = INT_W'(0) - neg_mag;
	assign int16_val = {{(INT_W-16){acc_next[15]}}, acc_next[15:0]};
	assign short_val = INT_W'(b) - SHORT_BIAS;

	// token state machine
	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		lead_d  = lead_q;
		acc_d   = acc_q;
		rs_d    = rs_q;
		emit    = 1'b0;
		tok     = '0;
		if (q_item.stream_end) begin
			emit     = 1'b1;
			tok.kind = KIND_ERR;
			tok.err  = ERR_END;
			phase_d  = PH_START;
			left_d   = 3'd0;
		end else begin
			unique case (phase_q)
				PH_INT: begin
					acc_d = acc_next;
					if (left_q > 3'd1) begin
						left_d = left_q - 3'd1;
					end else begin
						left_d   = 3'd0;
						phase_d  = PH_START;
						emit     = 1'b1;
						tok.kind = KIND_INT;
						priority if (lead_q >= LEAD_POS_FIRST && lead_q <= LEAD_POS_LAST)
							tok.int_val = pos_val;
						else if (lead_q >= LEAD_NEG_FIRST && lead_q <= LEAD_NEG_LAST)
							tok.int_val = neg_val;
						else if (lead_q == LEAD_INT16)
							tok.int_val = int16_val;
						else
							tok.int_val = acc_next;
					end
				end
				PH_REAL: begin
					rs_d = rs_fin;
					if (r_fin != NIB_MORE) begin
						phase_d = PH_START;
						emit    = 1'b1;
						if (r_fin == NIB_DONE) begin
							tok.kind    = KIND_REAL;
							tok.mant    = rs_fin.mant;
							tok.neg     = rs_fin.neg;
							tok.exp_neg = rs_fin.exp_neg;
							tok.exp_acc = rs_fin.exp_acc;
							tok.scale   = rs_fin.scale;
							tok.lost    = rs_fin.lost;
						end else begin
							tok.kind = KIND_ERR;
							tok.err  = (r_fin == NIB_RESERVED) ? ERR_RSVD : ERR_MALFORMED;
						end
					end
				end
				default: begin
					phase_d = PH_START;
					unique case (q_item.cls)
						CLS_OP: begin
							emit        = 1'b1;
							tok.kind    = KIND_OP;
							tok.op_code = b[OP_W-1:0];
						end
						CLS_REAL: begin
							rs_d    = '0;
							phase_d = PH_REAL;
						end
						CLS_RSVD: begin
							emit     = 1'b1;
							tok.kind = KIND_ERR;
							tok.err  = ERR_RSVD;
						end
						CLS_SHORT: begin
							emit        = 1'b1;
							tok.kind    = KIND_INT;
							tok.int_val = short_val;
						end
						CLS_LEAD: begin
							lead_d  = b;
							acc_d   = '0;
							phase_d = PH_INT;
							if (b == LEAD_INT16)
								left_d = 3'd2;
							else if (b == LEAD_INT32)
								left_d = 3'd4;
							else
								left_d = 3'd1;
						end
						default: begin
							phase_d = PH_START;
						end
					endcase
				end
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			left_q  <= 3'd0;
			lead_q  <= 8'd0;
			acc_q   <= '0;
			rs_q    <= '0;
		end else if (process) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			lead_q  <= lead_d;
			acc_q   <= acc_d;
			rs_q    <= rs_d;
		end
	end

	// stage register toward the output part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else if (process) begin
			tok_valid_s1 <= emit;
		end else if (tok_take) begin
			tok_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && emit)
			tok_s1 <= tok;
	end

`ifndef SYNTHESIS
	a_left_only_int: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_INT) |-> (left_q == 3'd0))
		else $error("byte count left over outside an integer operand");

	a_digits_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rs_q.digits <= DIG_W'(MANT_DIGITS))
		else $error("mantissa digit count above its limit");

	a_zero_mant: assert property (@(posedge clk) disable iff (!arst_n)
		(rs_q.digits == '0) |-> (rs_q.mant == '0))
		else $error("nonzero mantissa with no counted digit");
`endif

endmodule

/* hw/rtl/cdtd_emit.sv */
`timescale 1ns / 1ps
// Output part: applies sign to the mantissa, folds and clamps the exponent,
// and holds the finished token in the output register. Depends on cdtd_pkg.
module cdtd_emit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tok_valid_s1,
	input  cdtd_pkg::raw_tok_t              tok_s1,
	output logic                            tok_take,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cdtd_pkg::TDATA_W-1:0]    m_tdata,  // [4:0] operator_code, [36:5] integer_value,
	                                                  // [97:37] real_mantissa,
	                                                  // [108:98] real_exponent,
	                                                  // [109] precision_lost, [111:110] error_code
	output logic [1:0]                      m_tuser   // [1:0] token_kind
);
	import cdtd_pkg::*;

	localparam int EW2 = EXP_W + 2;
	localparam logic signed [EW2-1:0] E_HI = EW2'(2**(EXP_W-1) - 1);
	localparam logic signed [EW2-1:0] E_LO = EW2'(-(2**(EXP_W-1) - 1));

	logic                    out_valid_q;
	logic [1:0]              kind_q;
	logic [OP_W-1:0]         op_q;
	logic [INT_W-1:0]        int_q;
	logic [MANT_W:0]         mant_q;
	logic [EXP_W-1:0]        exp_q;
	logic                    lost_q;
	logic [1:0]              err_q;

	logic [EW2-1:0]          exp_ext;
	logic signed [EW2-1:0]   exp_signed;
	logic signed [EW2-1:0]   exp_sum;
	logic [EXP_W-1:0]        exp_out;
	logic                    clamp;
	logic [MANT_W:0]         mant_out;
	logic                    load;

	assign tok_take = !out_valid_q || m_tready;
	assign load     = tok_valid_s1 && tok_take;

	// written exponent plus mantissa scale, clamped
	assign exp_ext    = EW2'(tok_s1.exp_acc);
	assign exp_signed = tok_s1.exp_neg ? -$signed(exp_ext) : $signed(exp_ext);
	assign exp_sum    = exp_signed + EW2'(tok_s1.scale);

	always_comb begin
		exp_out = '0;
		clamp   = 1'b0;
		if (tok_s1.kind == KIND_REAL && tok_s1.mant != '0) begin
			priority if (exp_sum > E_HI) begin
				exp_out = E_HI[EXP_W-1:0];
				clamp   = 1'b1;
			end else if (exp_sum < E_LO) begin
				exp_out = E_LO[EXP_W-1:0];
				clamp   = 1'b1;
			end else begin
				exp_out = exp_sum[EXP_W-1:0];
			end
		end
	end

	// signed mantissa
	assign mant_out = tok_s1.neg ? ((MANT_W+1)'(0) - {1'b0, tok_s1.mant})
		: {1'b0, tok_s1.mant};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok_take) begin
			out_valid_q <= tok_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= tok_s1.kind;
			op_q   <= tok_s1.op_code;
			int_q  <= tok_s1.int_val;
			mant_q <= mant_out;
			exp_q  <= exp_out;
			lost_q <= tok_s1.lost | clamp;
			err_q  <= tok_s1.err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {err_q, lost_q, exp_q, mant_q, int_q, op_q};
	assign m_tuser  = kind_q;

`ifndef SYNTHESIS
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((kind_q == KIND_ERR) == (err_q != ERR_NONE)))
		else $error("error code does not match token kind");
`endif

endmodule

/* hw/rtl/cff_dict_token_decoder_unit.sv */
`timescale 1ns / 1ps
// CFF DICT token decoder, top level.
// Input channel (s_*): one DICT byte per item in s_tdata; s_tuser high marks
//   the end of the data, and then the byte is ignored and an end-of-data
//   error token follows.
// Output channel (m_*): one token per item; m_tuser gives the kind
//   (operator, integer, real, error) and m_tdata carries all value fields,
//   unused ones zero.
// Throughput: one byte per cycle when not stalled, real operand bytes included
//   (both nibbles of a byte are decoded in the same cycle by the back part).
// Path: a token goes from the queue slot of its last byte to the back stage,
//   then to the output register, which drives m_tvalid.
// Stall: a two-entry queue keeps s_tready high while the output waits; it
//   drops only when the queue is full. A held token stays stable on m_*.
// Reset: arst_n clears the queue and the output register and puts the
//   decoder at token start; s_tready is high during and after reset.
// Depends on cdtd_pkg, cdtd_front, cdtd_back, cdtd_emit.
module cff_dict_token_decoder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] byte_value
	input  logic                         s_tuser,   // [0] stream_end
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cdtd_pkg::TDATA_W-1:0] m_tdata,   // [4:0] operator_code,
	                                                // [36:5] integer_value,
	                                                // [97:37] real_mantissa,
	                                                // [108:98] real_exponent,
	                                                // [109] precision_lost,
	                                                // [111:110] error_code
	output logic [1:0]                   m_tuser    // [1:0] token_kind
);
	import cdtd_pkg::*;

	logic     q_valid;
	logic     q_pop;
	q_item_t  q_item;
	logic     tok_valid_s1;
	raw_tok_t tok_s1;
	logic     tok_take;

	// classify and queue
	cdtd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	// decode
	cdtd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item),
		.tok_valid_s1 (tok_valid_s1),
		.tok_s1       (tok_s1),
		.tok_take     (tok_take)
	);

	// finish and hand out
	cdtd_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid_s1 (tok_valid_s1),
		.tok_s1       (tok_s1),
		.tok_take     (tok_take),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule

/* dv/cdtd_token_checker.sv */
`timescale 1ns / 1ps
// Scoreboard of the CFF DICT token decoder: nibble codes of real operands,
// and a checker that predicts tokens from accepted bytes and compares them.
// Depends on cdtd_pkg.
package cdtd_tb_pkg;

	// nibble codes inside a real operand
	localparam logic [3:0] NIB_DIGIT_MAX = 4'h9;
	localparam logic [3:0] NIB_POINT     = 4'ha;
	localparam logic [3:0] NIB_EXP_POS   = 4'hb;
	localparam logic [3:0] NIB_EXP_NEG   = 4'hc;
	localparam logic [3:0] NIB_RSVD      = 4'hd;
	localparam logic [3:0] NIB_MINUS     = 4'he;
	localparam logic [3:0] NIB_STOP      = 4'hf;

endpackage

module cdtd_token_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] byte_value
	input  logic                         s_tuser,   // [0] stream_end
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [cdtd_pkg::TDATA_W-1:0] m_tdata,   // [4:0] operator_code,
	                                                // [36:5] integer_value,
	                                                // [97:37] real_mantissa,
	                                                // [108:98] real_exponent,
	                                                // [109] precision_lost,
	                                                // [111:110] error_code
	input  logic [1:0]                   m_tuser,   // [1:0] token_kind
	output int                           fail_count,
	output int                           tokens_queued
);
	import cdtd_pkg::*;
	import cdtd_tb_pkg::*;

	typedef enum logic [1:0] {
		AT_START,
		IN_INT,
		IN_REAL
	} dec_phase_t;

	typedef enum logic [1:0] {
		STEP_MORE,
		STEP_DONE,
		STEP_RSVD,
		STEP_BAD
	} step_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  op;
		logic [31:0] ival;
		logic [60:0] mant;
		logic [10:0] expo;
		logic        lost;
		logic [1:0]  err;
	} token_t;

	// decoder state as the predictor keeps it
	dec_phase_t  ph;
	logic [2:0]  bytes_left;
	logic [7:0]  lead;
	logic [31:0] iacc;
	logic [63:0] macc;
	int          mdig;
	int          eacc;
	int          scale;
	logic        past_int, in_exp, exp_neg, neg, started, lost;

	token_t pending_tokens[$];
	token_t want_tok;
	int     mismatch_count;

	// move the decimal scale, saturating
	function automatic void move_scale(input int d);
		int s;
		s = scale + d;
		if (s > int'(SCALE_MAX)) begin
			s = int'(SCALE_MAX);
			lost = 1'b1;
		end
		if (s < int'(SCALE_MIN)) begin
			s = int'(SCALE_MIN);
			lost = 1'b1;
		end
		scale = s;
	endfunction

	// one nibble of a real operand
	function automatic step_t take_nibble(input logic [3:0] n);
		step_t r;
		logic  frac;
		int    e;
		r = STEP_MORE;
		if (n <= NIB_DIGIT_MAX) begin
			if (!in_exp) begin
				frac = past_int;
				if (mdig < MANT_DIGITS) begin
					macc = macc * 64'd10 + 64'(n);
					if (macc != 0)
						mdig++;
					if (frac)
						move_scale(-1);
				end else begin
					// mantissa full: integer digits scale up, fraction digits drop
					if (!frac)
						move_scale(1);
					if (n != 0)
						lost = 1'b1;
				end
			end else begin
				e = eacc * 10 + int'(n);
				if (e > int'(EXP_ACC_MAX)) begin
					e = int'(EXP_ACC_MAX);
					lost = 1'b1;
				end
				eacc = e;
			end
		end else if (n == NIB_POINT) begin
			if (past_int)
				r = STEP_BAD;
			past_int = 1'b1;
		end else if (n == NIB_EXP_POS || n == NIB_EXP_NEG) begin
			if (in_exp)
				r = STEP_BAD;
			past_int = 1'b1;
			in_exp = 1'b1;
			if (n == NIB_EXP_NEG)
				exp_neg = 1'b1;
		end else if (n == NIB_MINUS) begin
			if (started)
				r = STEP_BAD;
			neg = 1'b1;
		end else if (n == NIB_STOP) begin
			r = STEP_DONE;
		end else begin
			r = STEP_RSVD;
		end
		started = 1'b1;
		return r;
	endfunction

	// finished real: fold exponent and scale, clamp, apply sign
	function automatic token_t real_token();
		token_t t;
		int e;
		logic [63:0] m;
		t = '0;
		e = 0;
		m = macc;
		if (m != 0) begin
			e = exp_neg ? -eacc : eacc;
			e += scale;
			if (e > int'(SCALE_MAX)) begin
				e = int'(SCALE_MAX);
				lost = 1'b1;
			end
			if (e < -int'(SCALE_MAX)) begin
				e = -int'(SCALE_MAX);
				lost = 1'b1;
			end
		end
		if (neg)
			m = 64'd0 - m;
		t.kind = KIND_REAL;
		t.mant = m[60:0];
		t.expo = e[10:0];
		t.lost = lost;
		return t;
	endfunction

	// predict the token, if any, that one accepted byte completes
	function automatic bit decode_item(input logic [7:0] b, input logic fin,
	                                   output token_t t);
		step_t r;
		t = '0;
		if (fin) begin
			t.kind = KIND_ERR;
			t.err = ERR_END;
			ph = AT_START;
			return 1'b1;
		end
		if (ph == IN_INT) begin
			iacc = {iacc[23:0], b};
			if (bytes_left > 1) begin
				bytes_left--;
				return 1'b0;
			end
			bytes_left = '0;
			ph = AT_START;
			t.kind = KIND_INT;
			if (lead >= LEAD_POS_FIRST && lead <= LEAD_POS_LAST)
				t.ival = (32'(lead - LEAD_POS_FIRST) << 8) + 32'(iacc[7:0]) + INT2_BIAS;
			else if (lead >= LEAD_NEG_FIRST && lead <= LEAD_NEG_LAST)
				t.ival = 32'd0 - ((32'(lead - LEAD_NEG_FIRST) << 8) + 32'(iacc[7:0])
				                  + INT2_BIAS);
			else if (lead == LEAD_INT16)
				t.ival = {{16{iacc[15]}}, iacc[15:0]};
			else
				t.ival = iacc;
			return 1'b1;
		end
		if (ph == IN_REAL) begin
			r = take_nibble(b[7:4]);
			if (r == STEP_MORE)
				r = take_nibble(b[3:0]);
			if (r == STEP_MORE)
				return 1'b0;
			ph = AT_START;
			if (r == STEP_DONE) begin
				t = real_token();
			end else begin
				t.kind = KIND_ERR;
				t.err = (r == STEP_RSVD) ? ERR_RSVD : ERR_MALFORMED;
			end
			return 1'b1;
		end
		// token start
		if (b <= OP_LAST) begin
			t.kind = KIND_OP;
			t.op = b[4:0];
			return 1'b1;
		end
		if (b == LEAD_REAL) begin
			macc = '0;
			mdig = 0;
			eacc = 0;
			scale = 0;
			{past_int, in_exp, exp_neg, neg, started, lost} = '0;
			ph = IN_REAL;
			return 1'b0;
		end
		if (b <= RSVD_LAST || b == RSVD_31 || b == RSVD_255) begin
			t.kind = KIND_ERR;
			t.err = ERR_RSVD;
			return 1'b1;
		end
		if (b >= SHORT_FIRST && b <= SHORT_LAST) begin
			t.kind = KIND_INT;
			t.ival = 32'(b) - SHORT_BIAS;
			return 1'b1;
		end
		lead = b;
		iacc = '0;
		if (b == LEAD_INT16)
			bytes_left = 3'd2;
		else if (b == LEAD_INT32)
			bytes_left = 3'd4;
		else
			bytes_left = 3'd1;
		ph = IN_INT;
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
	                                    input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// compare leaving tokens first, then predict from the accepted byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph <= AT_START;
			bytes_left <= '0;
			lead <= '0;
			iacc <= '0;
			macc <= '0;
			mdig <= 0;
			eacc <= 0;
			scale <= 0;
			{past_int, in_exp, exp_neg, neg, started, lost} <= '0;
			mismatch_count <= 0;
			fail_count <= 0;
			tokens_queued <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_tokens.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected token, expected none actual kind %0d data %h",
					         $time, m_tuser, m_tdata);
				end else begin
					want_tok = pending_tokens.pop_front();
					check_field("token_kind", 64'(want_tok.kind), 64'(m_tuser));
					check_field("operator_code", 64'(want_tok.op), 64'(m_tdata[4:0]));
					check_field("integer_value", 64'(want_tok.ival), 64'(m_tdata[36:5]));
					check_field("real_mantissa", 64'(want_tok.mant), 64'(m_tdata[97:37]));
					check_field("real_exponent", 64'(want_tok.expo), 64'(m_tdata[108:98]));
					check_field("precision_lost", 64'(want_tok.lost), 64'(m_tdata[109]));
					check_field("error_code", 64'(want_tok.err), 64'(m_tdata[111:110]));
				end
			end
			if (s_tvalid && s_tready) begin
				if (decode_item(s_tdata, s_tuser, want_tok))
					pending_tokens.push_back(want_tok);
			end
			fail_count <= mismatch_count;
			tokens_queued <= pending_tokens.size();
		end
	end

endmodule

/* dv/cff_dict_token_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the CFF DICT token decoder testbench: clock, reset, byte stimulus
// and output back-pressure, with the token checker beside the block.
// Depends on cdtd_pkg, cdtd_tb_pkg, cdtd_token_checker and the block itself.
module cff_dict_token_decoder_unit_tb;
	import cdtd_pkg::*;
	import cdtd_tb_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int TOTAL_BYTES = 1300;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;
	int                  fail_count;
	int                  tokens_queued;

	int         items_sent;
	int         idle_cycles;
	bit         no_gaps;
	bit         noise_on;
	logic [3:0] nibs[$];

	// opening bytes: operator and reserved extremes, every integer form, a real,
	// and a reserved nibble inside a real
	logic [7:0] opening_bytes [0:25] = '{
		8'd0, OP_LAST, 8'(OP_LAST + 8'd1), RSVD_31, RSVD_255, SHORT_FIRST, SHORT_LAST,
		LEAD_POS_FIRST, 8'h00, LEAD_NEG_LAST, 8'hff,
		LEAD_INT16, 8'h80, 8'h00,
		LEAD_INT32, 8'h7f, 8'hff, 8'hff, 8'hff,
		LEAD_REAL, {NIB_MINUS, 4'd2}, {NIB_POINT, 4'd5}, {NIB_EXP_NEG, 4'd3},
		{NIB_STOP, 4'd0},
		LEAD_REAL, {4'd1, NIB_RSVD}
	};

	cff_dict_token_decoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	cdtd_token_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.tokens_queued (tokens_queued)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= fin;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if ($urandom_range(0, 149) == 0)
			no_gaps = !no_gaps;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random part: now and then an end-of-data item cuts in
	task automatic put_byte(input logic [7:0] b);
		if (noise_on && $urandom_range(0, 79) == 0)
			send_byte(8'($urandom), 1'b1);
		send_byte(b, 1'b0);
	endtask

	task automatic add_digits(input int count, input int zero_pct);
		repeat (count)
			nibs.push_back(($urandom_range(0, 99) < zero_pct) ? 4'd0 :
			               4'($urandom_range(0, 9)));
	endtask

	// real lead byte, then the nibble string with its stop nibble; a stop in
	// the high nibble gets a random low nibble
	task automatic send_real();
		logic [3:0] hi;
		put_byte(LEAD_REAL);
		nibs.push_back(NIB_STOP);
		while (nibs.size() >= 2) begin
			hi = nibs.pop_front();
			put_byte({hi, nibs.pop_front()});
		end
		if (nibs.size() == 1)
			put_byte({nibs.pop_front(), 4'($urandom)});
	endtask

	function automatic int digit_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 6);
		if (r < 85)
			return $urandom_range(7, 17);
		return $urandom_range(18, 30);
	endfunction

	// random real; broken ones get one extra control nibble somewhere
	task automatic make_real(input bit broken);
		int zp;
		logic [3:0] bad [0:4];
		bad = '{NIB_POINT, NIB_EXP_POS, NIB_EXP_NEG, NIB_MINUS, NIB_RSVD};
		nibs.delete();
		zp = ($urandom_range(0, 1) == 0) ? 10 : 50;
		if ($urandom_range(0, 3) == 0)
			nibs.push_back(NIB_MINUS);
		add_digits(digit_count(), zp);
		if ($urandom_range(0, 1) == 0) begin
			nibs.push_back(NIB_POINT);
			if ($urandom_range(0, 3) == 0)
				add_digits($urandom_range(1, 10), 100);
			add_digits(digit_count(), zp);
		end
		if ($urandom_range(0, 4) < 2) begin
			nibs.push_back(($urandom_range(0, 1) == 0) ? NIB_EXP_POS : NIB_EXP_NEG);
			add_digits($urandom_range(0, 5), zp);
		end
		if (broken)
			nibs.insert($urandom_range(0, nibs.size()), bad[$urandom_range(0, 4)]);
		send_real();
	endtask

	// one random token or piece of noise
	task automatic random_token();
		int r;
		int i;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			put_byte(8'($urandom_range(0, OP_LAST)));
		end else if (r < 24) begin
			put_byte(8'($urandom_range(SHORT_FIRST, SHORT_LAST)));
		end else if (r < 38) begin
			put_byte(8'($urandom_range(LEAD_POS_FIRST, LEAD_NEG_LAST)));
			put_byte(8'($urandom));
		end else if (r < 50) begin
			if ($urandom_range(0, 1) == 0) begin
				put_byte(LEAD_INT16);
				for (i = 0; i < 2; i++)
					put_byte(8'($urandom));
			end else begin
				put_byte(LEAD_INT32);
				for (i = 0; i < 4; i++)
					put_byte(8'($urandom));
			end
		end else if (r < 80) begin
			make_real(1'b0);
		end else if (r < 88) begin
			make_real(1'b1);
		end else if (r < 94) begin
			case ($urandom_range(0, 2))
				0: put_byte(8'($urandom_range(OP_LAST + 1, RSVD_LAST)));
				1: put_byte(RSVD_31);
				default: put_byte(RSVD_255);
			endcase
		end else if (r < 97) begin
			put_byte(8'($urandom));
		end else begin
			send_byte(8'($urandom), 1'b1);
		end
	endtask

	// output side: random stalls, mostly short, a few long, some long ready runs
	initial begin
		int stall;
		int run;
		int r;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 50)
				stall = 0;
			else if (r < 85)
				stall = $urandom_range(1, 3);
			else
				stall = $urandom_range(10, 60);
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
			      $urandom_range(1, 20);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int i;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		items_sent = 0;
		no_gaps = 1'b0;
		noise_on = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fixed bytes, end of data at token start and inside a token
		for (i = 0; i < 26; i++)
			send_byte(opening_bytes[i], 1'b0);
		send_byte(8'($urandom), 1'b1);
		send_byte(LEAD_INT16, 1'b0);
		send_byte(8'($urandom), 1'b1);

		// scale saturation both ways: long integer part, long run of fraction zeros
		nibs.delete();
		nibs.push_back(4'd1);
		add_digits(1045, 0);
		send_real();
		nibs.delete();
		nibs.push_back(NIB_POINT);
		add_digits(1030, 100);
		nibs.push_back(4'd1);
		send_real();

		// random tokens until the byte budget is used up
		noise_on = 1'b1;
		while (items_sent < TOTAL_BYTES)
			random_token();
		s_tvalid <= 1'b0;

		// drain, then a short tail to catch stray tokens
		do @(posedge clk); while (tokens_queued != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
